// ===== sv/rv32_exe_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32_exe_pkg
// Shared types and codes for the RV32I subset execute unit.
// ----------------------------------------------------------------------------
package rv32_exe_pkg;

  localparam int DATA_WORDS_DEF = 16384;
  localparam int PROG_W         = 17;

  typedef enum logic [1:0] {
    CMD_EXEC    = 2'd0,
    CMD_PRELOAD = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_WORD = 3'd2;

  localparam logic [31:0] DMEM_INIT = 32'h0000_00ff;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] instr_word;
    logic [13:0] target_index;
    logic [31:0] preload_value;
  } exe_req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic        reg_written;
    logic        store_done;
    logic [13:0] store_index;
    logic [31:0] store_value;
    logic [31:0] read_result;
    logic        beyond_program;
    logic        unsupported;
  } exe_rsp_t;

endpackage

// ===== sv/rv32i_subset_execute_unit.sv =====
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit
// Three-stage execute core for an RV32I subset with register file and word
// data memory held in synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in_*      input      in_valid / in_stall     exe_req_t
//  out_*     output     out_valid / out_stall   exe_rsp_t
//  cfg_*     input      APB write/read          program_words at 0x0
//
//  One request per cycle while in_stall is low; passes s1, s2, then out_data.
//  Operands come from the register RAM, a write-back bypass and the
//  execute/memory stage; load data is bypassed straight from the RAM output.
//  After reset the data RAM is swept to 0xFF and the register RAM to zero
//  with in_stall high throughout. Up to three requests are held;
//  behind an output stall in_stall rises once all three stages are full.
module rv32i_subset_execute_unit
  import rv32_exe_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  exe_req_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output exe_rsp_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(DATA_WORDS);

  function automatic logic [AW-1:0] wrap_idx(input logic [13:0] v);
    logic [17:0] t;
    t = {4'd0, v};
    for (int k = 3; k >= 0; k--) begin
      if (t >= (18'(DATA_WORDS) << k)) begin
        t = t - (18'(DATA_WORDS) << k);
      end
    end
    return t[AW-1:0];
  endfunction

  // config
  logic [PROG_W-1:0] prog_words_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {15'd0, prog_words_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_words_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      prog_words_r <= cfg_pwdata[PROG_W-1:0];
    end
  end

  // memories
  logic [31:0] rf_mem [32];
  logic [31:0] dm_mem [DATA_WORDS];
  logic [31:0] rf_q1, rf_q2, dm_q;

  // pipeline control
  logic        clr_r;
  logic [AW-1:0] clr_cnt_r;
  logic        s1_v_r, s2_v_r, out_v_r;
  exe_req_t    s1_r;
  logic        out_rdy, s2_rdy, s1_rdy, s2_adv, s1_adv, in_acc, s1_hold, s2_hold;

  assign out_rdy  = !out_v_r || !out_stall;
  assign s2_adv   = s2_v_r && out_rdy;
  assign s2_rdy   = !s2_v_r || out_rdy;
  assign s1_adv   = s1_v_r && s2_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = clr_r || !s1_rdy;
  assign in_acc   = in_valid && !in_stall;
  assign s1_hold  = s1_v_r && !s1_adv;
  assign s2_hold  = s2_v_r && !s2_adv;

  // stage 2 registers
  logic [31:0]   pc_r;
  logic [31:0]   s2_npc_r, s2_val_r, s2_sval_r, s2_rres_r;
  logic [4:0]    s2_rd_r;
  logic          s2_wr_r, s2_ld_r, s2_st_r, s2_bey_r, s2_bad_r;
  logic [AW-1:0] s2_idx_r;

  // write-back bypass
  logic        wb_v_r;
  logic [4:0]  wb_rd_r;
  logic [31:0] wb_val_r;

  logic [31:0] s2_fwd;
  logic        s2_rw;
  assign s2_fwd = s2_ld_r ? dm_q : s2_val_r;
  assign s2_rw  = s2_v_r && s2_wr_r && (s2_rd_r != 5'd0);

  // register reads
  logic [4:0] in_ra1, in_ra2, s1_ra1, s1_ra2;
  assign in_ra1 = (in_data.cmd == CMD_READ) ? in_data.target_index[4:0]
                                             : in_data.instr_word[19:15];
  assign in_ra2 = in_data.instr_word[24:20];
  assign s1_ra1 = (s1_r.cmd == CMD_READ) ? s1_r.target_index[4:0]
                                          : s1_r.instr_word[19:15];
  assign s1_ra2 = s1_r.instr_word[24:20];

  function automatic logic [31:0] fwd(input logic [4:0] ra, input logic [31:0] q,
                                      input logic s2w, input logic [4:0] s2d,
                                      input logic [31:0] s2x, input logic wv,
                                      input logic [4:0] wd, input logic [31:0] wx);
    logic [31:0] r;
    if (ra == 5'd0) r = 32'd0;
    else if (s2w && s2d == ra) r = s2x;
    else if (wv && wd == ra) r = wx;
    else r = q;
    return r;
  endfunction

  // stage 1 execute
  logic [31:0]   a, b, immi, imms, immb, immj, npc, rdv, pc4, sum_i, sum_s;
  logic [4:0]    sh, rd;
  logic [6:0]    op, f7;
  logic [2:0]    f3;
  logic          wr, ld, st, bad, take;
  logic [AW-1:0] ld_idx, st_idx, pre_idx;
  logic [31:0]   rres;

  always_comb begin
    a     = fwd(s1_ra1, rf_q1, s2_rw, s2_rd_r, s2_fwd, wb_v_r, wb_rd_r, wb_val_r);
    b     = fwd(s1_ra2, rf_q2, s2_rw, s2_rd_r, s2_fwd, wb_v_r, wb_rd_r, wb_val_r);
    op    = s1_r.instr_word[6:0];
    rd    = s1_r.instr_word[11:7];
    f3    = s1_r.instr_word[14:12];
    f7    = s1_r.instr_word[31:25];
    sh    = s1_r.instr_word[24:20];
    immi  = {{20{s1_r.instr_word[31]}}, s1_r.instr_word[31:20]};
    imms  = {{20{s1_r.instr_word[31]}}, s1_r.instr_word[31:25], s1_r.instr_word[11:7]};
    immb  = {{20{s1_r.instr_word[31]}}, s1_r.instr_word[7], s1_r.instr_word[30:25],
             s1_r.instr_word[11:8], 1'b0};
    immj  = {{12{s1_r.instr_word[31]}}, s1_r.instr_word[19:12], s1_r.instr_word[20],
             s1_r.instr_word[30:21], 1'b0};
    pc4   = pc_r + 32'd4;
    sum_i = a + immi;
    sum_s = a + imms;
    ld_idx  = wrap_idx(sum_i[15:2]);
    st_idx  = wrap_idx(sum_s[15:2]);
    pre_idx = wrap_idx(s1_r.target_index);
    npc  = pc_r;
    rdv  = 32'd0;
    wr   = 1'b0;
    ld   = 1'b0;
    st   = 1'b0;
    bad  = 1'b0;
    take = 1'b0;
    rres = 32'd0;
    case (s1_r.cmd)
      CMD_EXEC: begin
        npc = pc4;
        case (op)
          OP_LUI: begin
            rdv = {s1_r.instr_word[31:12], 12'd0};
            wr  = 1'b1;
          end
          OP_AUIPC: begin
            rdv = pc_r + {s1_r.instr_word[31:12], 12'd0};
            wr  = 1'b1;
          end
          OP_JAL: begin
            rdv = pc4;
            wr  = 1'b1;
            npc = pc_r + immj;
          end
          OP_JALR: begin
            rdv = pc4;
            wr  = 1'b1;
            npc = {sum_i[31:1], 1'b0};
          end
          OP_BRANCH: begin
            case (f3)
              F3_BEQ: take = (a == b);
              F3_BNE: take = (a != b);
              F3_BLT: take = ($signed(a) < $signed(b));
              F3_BGE: take = !($signed(a) < $signed(b));
              default: bad = 1'b1;
            endcase
            if (take) npc = pc_r + immb;
          end
          OP_LOAD: begin
            if (f3 == F3_WORD) begin
              ld = 1'b1;
              wr = 1'b1;
            end else begin
              bad = 1'b1;
            end
          end
          OP_STORE: begin
            if (f3 == F3_WORD) st = 1'b1;
            else bad = 1'b1;
          end
          OP_IMM: begin
            wr = 1'b1;
            case (f3)
              F3_ADD: rdv = sum_i;
              F3_SLT: rdv = {31'd0, $signed(a) < $signed(immi)};
              F3_XOR: rdv = a ^ immi;
              F3_OR:  rdv = a | immi;
              F3_AND: rdv = a & immi;
              F3_SLL: rdv = a << sh;
              F3_SR: begin
                if (f7 == F7_ZERO) rdv = a >> sh;
                else if (f7 == F7_ALT) rdv = $unsigned($signed(a) >>> sh);
                else begin
                  bad = 1'b1;
                  wr  = 1'b0;
                end
              end
              default: begin
                bad = 1'b1;
                wr  = 1'b0;
              end
            endcase
          end
          OP_REG: begin
            wr = 1'b1;
            case (f3)
              F3_ADD: begin
                if (f7 == F7_ZERO) rdv = a + b;
                else if (f7 == F7_ALT) rdv = a - b;
                else begin
                  bad = 1'b1;
                  wr  = 1'b0;
                end
              end
              F3_SLL: rdv = a << b[4:0];
              F3_SLT: rdv = {31'd0, $signed(a) < $signed(b)};
              F3_XOR: rdv = a ^ b;
              F3_SR: begin
                if (f7 == F7_ZERO) rdv = a >> b[4:0];
                else if (f7 == F7_ALT) rdv = $unsigned($signed(a) >>> b[4:0]);
                else begin
                  bad = 1'b1;
                  wr  = 1'b0;
                end
              end
              F3_OR:  rdv = a | b;
              F3_AND: rdv = a & b;
              default: begin
                bad = 1'b1;
                wr  = 1'b0;
              end
            endcase
          end
          default: bad = 1'b1;
        endcase
      end
      CMD_READ: rres = (s1_r.target_index < 14'd32) ? a : 32'd0;
      CMD_PRELOAD: ;
      default: bad = 1'b1;
    endcase
  end

  // register RAM, zeroed by the reset sweep
  always_ff @(posedge clk) begin
    if (clr_r) begin
      rf_mem[clr_cnt_r[4:0]] <= 32'd0;
    end else if (s2_adv && s2_rw) begin
      rf_mem[s2_rd_r] <= s2_fwd;
    end
    rf_q1 <= rf_mem[s1_hold ? s1_ra1 : in_ra1];
    rf_q2 <= rf_mem[s1_hold ? s1_ra2 : in_ra2];
  end

  // data RAM
  logic          dm_we;
  logic [AW-1:0] dm_wa, dm_ra;
  logic [31:0]   dm_wd;
  always_comb begin
    dm_we = 1'b0;
    dm_wa = clr_cnt_r;
    dm_wd = DMEM_INIT;
    if (clr_r) begin
      dm_we = 1'b1;
    end else if (s1_adv && s1_r.cmd == CMD_PRELOAD) begin
      dm_we = 1'b1;
      dm_wa = pre_idx;
      dm_wd = s1_r.preload_value;
    end else if (s1_adv && st) begin
      dm_we = 1'b1;
      dm_wa = st_idx;
      dm_wd = b;
    end
    dm_ra = s2_hold ? s2_idx_r : ld_idx;
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_wa] <= dm_wd;
    end
    dm_q <= dm_mem[dm_ra];
  end

  // control and pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      pc_r      <= 32'd0;
      wb_v_r    <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DATA_WORDS - 1)) clr_r <= 1'b0;
      end
      if (in_acc) s1_v_r <= 1'b1;
      else if (s1_adv) s1_v_r <= 1'b0;
      if (s1_adv) s2_v_r <= 1'b1;
      else if (s2_adv) s2_v_r <= 1'b0;
      if (s2_adv) out_v_r <= 1'b1;
      else if (out_rdy) out_v_r <= 1'b0;
      if (s1_adv) pc_r <= npc;
      if (s2_adv && s2_rw) wb_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= in_data;
    if (s1_adv) begin
      s2_npc_r  <= npc;
      s2_val_r  <= rdv;
      s2_rd_r   <= rd;
      s2_wr_r   <= (s1_r.cmd == CMD_EXEC) && wr;
      s2_ld_r   <= (s1_r.cmd == CMD_EXEC) && ld;
      s2_st_r   <= (s1_r.cmd == CMD_EXEC) && st;
      s2_idx_r  <= ld ? ld_idx : st_idx;
      s2_sval_r <= b;
      s2_rres_r <= rres;
      s2_bey_r  <= ({2'd0, npc[31:2]} >= {15'd0, prog_words_r});
      s2_bad_r  <= bad;
    end
    if (s2_adv && s2_rw) begin
      wb_rd_r  <= s2_rd_r;
      wb_val_r <= s2_fwd;
    end
    if (s2_adv) begin
      out_data.next_pc        <= s2_npc_r;
      out_data.dest_reg       <= s2_wr_r ? s2_rd_r : 5'd0;
      out_data.dest_value     <= s2_wr_r ? s2_fwd : 32'd0;
      out_data.reg_written    <= s2_wr_r && (s2_rd_r != 5'd0);
      out_data.store_done     <= s2_st_r;
      out_data.store_index    <= s2_st_r ? 14'(s2_idx_r) : 14'd0;
      out_data.store_value    <= s2_st_r ? s2_sval_r : 32'd0;
      out_data.read_result    <= s2_rres_r;
      out_data.beyond_program <= s2_bey_r;
      out_data.unsupported    <= s2_bad_r;
    end
  end

  assign out_valid = out_v_r;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for the RV32I subset execute unit: directed table, then random
// instruction streams and data preloads with random idling on both sides,
// checked field by field against a behavioral model of the core.
// ----------------------------------------------------------------------------
module tb;
  import rv32_exe_pkg::*;

  localparam int WATCHDOG = 100000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  exe_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  exe_rsp_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  rv32i_subset_execute_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // core model state
  logic [31:0] core_pc;
  logic [31:0] core_regs [32];
  logic [31:0] core_mem [DATA_WORDS_DEF];
  logic [16:0] core_prog_words;

  exe_rsp_t rsp_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_out = 1'b0;

  typedef struct {
    exe_req_t req;
    bit       known;
    exe_rsp_t rsp;
  } vec_t;

  function automatic logic [31:0] sx(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic bit lt_s(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [13:0] word_idx(logic [31:0] addr);
    return addr[15:2];
  endfunction

  function automatic exe_rsp_t core_execute(exe_req_t r);
    exe_rsp_t o;
    logic [31:0] iw, a, b, immi, v, npc, imm;
    logic [6:0] op, f7;
    logic [4:0] rd, sh;
    logic [2:0] f3;
    bit wr, bad, take;
    o = '0;
    iw = r.instr_word;
    npc = core_pc;
    wr = 0; bad = 0; take = 0; v = 0;
    case (r.cmd)
      CMD_PRELOAD: core_mem[r.target_index] = r.preload_value;
      CMD_READ: o.read_result = r.target_index < 32 ? core_regs[r.target_index[4:0]] : 0;
      CMD_NONE: bad = 1;
      default: begin
        op = iw[6:0]; rd = iw[11:7]; f3 = iw[14:12]; f7 = iw[31:25];
        a = core_regs[iw[19:15]]; b = core_regs[iw[24:20]];
        immi = sx(iw >> 20, 12); sh = iw[24:20];
        npc = core_pc + 4;
        case (op)
          OP_LUI: begin v = iw & 32'hFFFFF000; wr = 1; end
          OP_AUIPC: begin v = core_pc + (iw & 32'hFFFFF000); wr = 1; end
          OP_JAL: begin
            imm = {11'd0, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
            v = core_pc + 4; wr = 1; npc = core_pc + sx(imm, 21);
          end
          OP_JALR: begin v = core_pc + 4; wr = 1; npc = (a + immi) & ~32'd1; end
          OP_BRANCH: begin
            imm = {19'd0, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
            case (f3)
              F3_BEQ: take = a == b;
              F3_BNE: take = a != b;
              F3_BLT: take = lt_s(a, b);
              F3_BGE: take = !lt_s(a, b);
              default: bad = 1;
            endcase
            if (take) npc = core_pc + sx(imm, 13);
          end
          OP_LOAD:
            if (f3 == F3_WORD) begin v = core_mem[word_idx(a + immi)]; wr = 1; end
            else bad = 1;
          OP_STORE:
            if (f3 == F3_WORD) begin
              o.store_index = word_idx(a + sx({f7, rd}, 12));
              o.store_value = b; o.store_done = 1;
              core_mem[o.store_index] = b;
            end else bad = 1;
          OP_IMM: begin
            wr = 1;
            case (f3)
              F3_ADD: v = a + immi;
              F3_SLT: v = {31'd0, lt_s(a, immi)};
              F3_XOR: v = a ^ immi;
              F3_OR: v = a | immi;
              F3_AND: v = a & immi;
              F3_SLL: v = a << sh;
              F3_SR:
                if (f7 == F7_ZERO) v = a >> sh;
                else if (f7 == F7_ALT) v = $signed(a) >>> sh;
                else begin bad = 1; wr = 0; end
              default: begin bad = 1; wr = 0; end
            endcase
          end
          OP_REG: begin
            wr = 1;
            case (f3)
              F3_ADD:
                if (f7 == F7_ZERO) v = a + b;
                else if (f7 == F7_ALT) v = a - b;
                else begin bad = 1; wr = 0; end
              F3_SLL: v = a << b[4:0];
              F3_SLT: v = {31'd0, lt_s(a, b)};
              F3_XOR: v = a ^ b;
              F3_SR:
                if (f7 == F7_ZERO) v = a >> b[4:0];
                else if (f7 == F7_ALT) v = $signed(a) >>> b[4:0];
                else begin bad = 1; wr = 0; end
              F3_OR: v = a | b;
              F3_AND: v = a & b;
              default: begin bad = 1; wr = 0; end
            endcase
          end
          default: bad = 1;
        endcase
        if (wr && rd != 0) core_regs[rd] = v;
        if (wr) begin
          o.dest_reg = rd; o.dest_value = v; o.reg_written = rd != 0;
        end
        core_pc = npc;
      end
    endcase
    o.next_pc = npc;
    o.beyond_program = {2'd0, npc[31:2]} >= {15'd0, core_prog_words};
    o.unsupported = bad;
    return o;
  endfunction

  task automatic cfg_write(logic [16:0] words);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= '0; cfg_pwdata <= {15'd0, words};
    @(negedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    core_prog_words = words;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic send(exe_req_t r, bit known = 0, exe_rsp_t rsp = '0);
    exe_rsp_t e;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; in_data <= r;
    do @(posedge clk); while (in_stall);
    e = core_execute(r);
    if (known && e !== rsp) begin
      $error("directed row: expected %h actual model %h", rsp, e);
      errors++;
    end
    rsp_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (rsp_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // instruction builders
  function automatic logic [31:0] i_type(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                         logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] r_type(logic [2:0] f3, logic [6:0] f7, logic [4:0] rd,
                                         logic [4:0] rs1, logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic exe_req_t mk(cmd_t c, logic [31:0] iw, logic [13:0] ti = '0,
                                  logic [31:0] pv = '0);
    exe_req_t r;
    r.cmd = c; r.instr_word = iw; r.target_index = ti; r.preload_value = pv;
    return r;
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [31:0] iw;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [6:0] ops [9] = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH,
                             OP_LOAD, OP_STORE, OP_IMM, OP_REG};
    iw = $urandom;
    if ($urandom_range(0, 19) == 0) return iw;
    iw[6:0] = ops[$urandom_range(0, 8)];
    iw[19:15] = 5'($urandom_range(0, 7));
    iw[24:20] = 5'((iw[6:0] == OP_IMM || iw[6:0] == OP_REG) ? $urandom
                                                            : $urandom_range(0, 7));
    if ($urandom_range(0, 9) != 0) begin
      f7 = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
      if (iw[6:0] == OP_REG || (iw[6:0] == OP_IMM && iw[14:12] == F3_SR)) iw[31:25] = f7;
      if (iw[6:0] == OP_LOAD || iw[6:0] == OP_STORE) iw[14:12] = F3_WORD;
    end
    return iw;
  endfunction

  function automatic exe_rsp_t rsp_plain(logic [31:0] npc, bit beyond, bit bad,
                                         logic [31:0] rr = 0);
    exe_rsp_t o;
    o = '0; o.next_pc = npc; o.beyond_program = beyond; o.unsupported = bad;
    o.read_result = rr;
    return o;
  endfunction

  // result checking
  always @(posedge clk) begin
    exe_rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rsp_q.size() == 0) begin
        $error("unexpected response %h", out_data);
        errors++;
      end else begin
        e = rsp_q.pop_front();
        if (out_data.next_pc !== e.next_pc) begin
          $error("next_pc exp %h act %h", e.next_pc, out_data.next_pc); errors++; end
        if (out_data.dest_reg !== e.dest_reg) begin
          $error("dest_reg exp %h act %h", e.dest_reg, out_data.dest_reg); errors++; end
        if (out_data.dest_value !== e.dest_value) begin
          $error("dest_value exp %h act %h", e.dest_value, out_data.dest_value); errors++; end
        if (out_data.reg_written !== e.reg_written) begin
          $error("reg_written exp %h act %h", e.reg_written, out_data.reg_written); errors++; end
        if (out_data.store_done !== e.store_done) begin
          $error("store_done exp %h act %h", e.store_done, out_data.store_done); errors++; end
        if (out_data.store_index !== e.store_index) begin
          $error("store_index exp %h act %h", e.store_index, out_data.store_index); errors++; end
        if (out_data.store_value !== e.store_value) begin
          $error("store_value exp %h act %h", e.store_value, out_data.store_value); errors++; end
        if (out_data.read_result !== e.read_result) begin
          $error("read_result exp %h act %h", e.read_result, out_data.read_result); errors++; end
        if (out_data.beyond_program !== e.beyond_program) begin
          $error("beyond_program exp %h act %h", e.beyond_program, out_data.beyond_program);
          errors++; end
        if (out_data.unsupported !== e.unsupported) begin
          $error("unsupported exp %h act %h", e.unsupported, out_data.unsupported); errors++; end
      end
    end
  end

  // output stall bursts, plus one long hold-off
  always @(negedge clk) begin
    if (hold_out) out_stall <= 1;
    else if (quiet) out_stall <= 0;
    else if (out_stall) out_stall <= $urandom_range(0, 2) != 0;
    else out_stall <= $urandom_range(0, 6) == 0;
  end

  // watchdog: the reset sweep also runs without traffic
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("rv32i_subset_execute_unit regression: fail");
      $finish;
    end
  end

  initial begin
    vec_t dir [$];
    exe_req_t r;
    int n;
    core_pc = 0;
    core_prog_words = 0;
    foreach (core_regs[i]) core_regs[i] = 0;
    foreach (core_mem[i]) core_mem[i] = DMEM_INIT;
    repeat (4) @(negedge clk);
    rst_n <= 1;

    // reset state visible without config
    dir.push_back('{mk(CMD_READ, 0, 14'd31), 1, rsp_plain(0, 1, 0)});
    dir.push_back('{mk(CMD_EXEC, i_type(OP_LOAD, F3_WORD, 5'd1, 5'd0, 12'd0)), 0, '0});
    dir.push_back('{mk(CMD_NONE, 32'hFFFFFFFF, 14'h3FFF, 32'hFFFFFFFF), 1,
                    rsp_plain(4, 1, 1)});
    dir.push_back('{mk(CMD_EXEC, {20'hFFFFF, 5'd2, OP_LUI}), 0, '0});
    dir.push_back('{mk(CMD_EXEC, {20'h80000, 5'd0, OP_AUIPC}), 0, '0});
    dir.push_back('{mk(CMD_EXEC, i_type(OP_IMM, F3_ADD, 5'd3, 5'd0, 12'h7FF)), 0, '0});
    dir.push_back('{mk(CMD_EXEC, i_type(OP_IMM, F3_ADD, 5'd4, 5'd0, 12'h800)), 0, '0});
    dir.push_back('{mk(CMD_EXEC, i_type(OP_IMM, F3_SR, 5'd5, 5'd2, {F7_ALT, 5'd31})), 0, '0});
    dir.push_back('{mk(CMD_EXEC, i_type(OP_IMM, F3_SR, 5'd6, 5'd2, {F7_ZERO, 5'd31})), 0, '0});
    dir.push_back('{mk(CMD_EXEC, i_type(OP_IMM, F3_SR, 5'd6, 5'd2, 12'h7FF)), 0, '0});
    dir.push_back('{mk(CMD_EXEC, r_type(F3_ADD, F7_ALT, 5'd7, 5'd0, 5'd4)), 0, '0});
    dir.push_back('{mk(CMD_EXEC, r_type(F3_SLT, F7_ZERO, 5'd8, 5'd2, 5'd3)), 0, '0});
    dir.push_back('{mk(CMD_EXEC, r_type(F3_SLL, F7_ZERO, 5'd0, 5'd3, 5'd2)), 0, '0});
    dir.push_back('{mk(CMD_EXEC, r_type(F3_AND, 7'h7F, 5'd9, 5'd3, 5'd2)), 0, '0});
    dir.push_back('{mk(CMD_PRELOAD, 0, 14'h3FFF, 32'hA5A5_5A5A), 0, '0});
    dir.push_back('{mk(CMD_EXEC, {7'h7F, 5'd3, 5'd4, F3_WORD, 5'h1F, OP_STORE}), 0, '0});
    dir.push_back('{mk(CMD_EXEC, i_type(OP_LOAD, F3_WORD, 5'd10, 5'd0, 12'hFFC)), 0, '0});
    dir.push_back('{mk(CMD_EXEC, {7'h7F, 5'd3, 5'd2, F3_BLT, 5'h1F, OP_BRANCH}), 0, '0});
    dir.push_back('{mk(CMD_EXEC, {7'h00, 5'd3, 5'd3, 3'd2, 5'h00, OP_BRANCH}), 0, '0});
    dir.push_back('{mk(CMD_EXEC, {20'h80000, 5'd11, OP_JAL}), 0, '0});
    dir.push_back('{mk(CMD_EXEC, i_type(OP_JALR, 3'd0, 5'd12, 5'd2, 12'h801)), 0, '0});
    dir.push_back('{mk(CMD_EXEC, 32'h0000_007F), 0, '0});
    dir.push_back('{mk(CMD_READ, 0, 14'd11), 0, '0});
    dir.push_back('{mk(CMD_READ, 0, 14'd32), 0, '0});
    foreach (dir[i]) send(dir[i].req, dir[i].known, dir[i].rsp);
    drain();

    cfg_write(17'h1FFFF & 17'd65536);
    for (n = 0; n < 380; n++) begin
      if (n == 100) begin drain(); cfg_write(17'd0); end
      if (n == 200) begin drain(); cfg_write(17'($urandom_range(1, 4096))); end
      if (n == 150) begin
        fork begin hold_out = 1; repeat (30) @(negedge clk); hold_out = 0; end join_none
      end
      if (n == 330) quiet = 1;
      case ($urandom_range(0, 15))
        0: r = mk(CMD_PRELOAD, $urandom, 14'($urandom), $urandom);
        1: r = mk(CMD_READ, $urandom, 14'($urandom_range(0, 1) ? $urandom_range(0, 31)
                  : $urandom), $urandom);
        2: r = mk(cmd_t'($urandom_range(0, 3)), $urandom, 14'($urandom), $urandom);
        default: r = mk(CMD_EXEC, rand_instr(), 14'($urandom), $urandom);
      endcase
      send(r);
    end

    in_valid <= 0;
    n = 0;
    while (rsp_q.size() != 0 && n < 2000) begin @(negedge clk); n++; end
    repeat (10) @(negedge clk);
    if (errors == 0 && rsp_q.size() == 0)
      $display("rv32i_subset_execute_unit regression: pass");
    else
      $display("rv32i_subset_execute_unit regression: fail");
    $finish;
  end
endmodule

// ===== rv32i_subset_execute_unit.f =====
sv/rv32_exe_pkg.sv
sv/rv32i_subset_execute_unit.sv
sim/tb.sv
